@@ design/mcid_pkg.sv @@
// Shared types and constants for the multi-channel input debouncer.
package mcid_pkg;

    // Default structure of the block.
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int COUNT_WIDTH_DEF  = 14;

    // Fixed field widths.
    localparam int IN_W       = 8;
    localparam int THR_W      = 14;
    localparam int MAP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAP_CHANNELS = MAP_W / 2;

    // Register reset values.
    localparam logic [THR_W-1:0] RST_NORMAL_THR = THR_W'(100);
    localparam logic [THR_W-1:0] RST_FAST_THR   = THR_W'(50);
    localparam logic [THR_W-1:0] RST_SLOW_THR   = THR_W'(10000);
    localparam logic [MAP_W-1:0] RST_CLASS_MAP  = MAP_W'(18710);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FAST_THR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_THR   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_MAP  = CFG_IDX_W'(3);

    // Channel class codes; the unused code behaves as normal.
    localparam logic [1:0] CLASS_NORMAL = 2'd0;
    localparam logic [1:0] CLASS_FAST   = 2'd1;
    localparam logic [1:0] CLASS_SLOW   = 2'd2;

    // The three thresholds that every lane chooses from.
    typedef struct packed {
        logic [THR_W-1:0] normal_thr;
        logic [THR_W-1:0] fast_thr;
        logic [THR_W-1:0] slow_thr;
    } t_thresholds;

    // One result item.
    typedef struct packed {
        logic [IN_W-1:0] debounced;
        logic [IN_W-1:0] rose;
        logic [IN_W-1:0] fell;
    } t_result;

endpackage

@@ design/multi_channel_input_debouncer_top.sv @@
// Top level of the multi-channel input debouncer.
// Each input transfer is one sample tick of up to eight raw inputs. Every channel
// has its own lane with a saturating disagreement counter; when the count reaches
// the threshold of the channel's class (normal, fast or slow, set by the class
// map) the debounced bit flips. The block takes one transfer per clock cycle while
// its output buffer has room; each result is registered in that buffer, whose
// two entries (main and skid) let one further transfer in during an output
// stall. Configuration writes take effect on the next clock edge and must
// be made while the block is idle. No clearing pass follows reset.
module multi_channel_input_debouncer_top #(
    parameter int NUM_CHANNELS = mcid_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = mcid_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mcid_pkg::IN_W-1:0]       i_raw_inputs,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mcid_pkg::IN_W-1:0]       o_debounced_inputs,
    output logic [mcid_pkg::IN_W-1:0]       o_rose_mask,
    output logic [mcid_pkg::IN_W-1:0]       o_fell_mask,
    input  logic                            i_cfg_we,
    input  logic [mcid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcid_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mcid_pkg::t_thresholds        r_thr;
    logic [mcid_pkg::MAP_W-1:0]   r_class_map;
    logic                         step;
    logic [NUM_CHANNELS-1:0]      deb_cur;
    logic [NUM_CHANNELS-1:0]      deb_next;
    logic [mcid_pkg::IN_W-1:0]    out_cur;
    logic [mcid_pkg::IN_W-1:0]    out_next;
    mcid_pkg::t_result            result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.normal_thr <= mcid_pkg::RST_NORMAL_THR;
            r_thr.fast_thr   <= mcid_pkg::RST_FAST_THR;
            r_thr.slow_thr   <= mcid_pkg::RST_SLOW_THR;
            r_class_map      <= mcid_pkg::RST_CLASS_MAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mcid_pkg::REG_NORMAL_THR: r_thr.normal_thr <= i_cfg_data[mcid_pkg::THR_W-1:0];
                mcid_pkg::REG_FAST_THR:   r_thr.fast_thr   <= i_cfg_data[mcid_pkg::THR_W-1:0];
                mcid_pkg::REG_SLOW_THR:   r_thr.slow_thr   <= i_cfg_data[mcid_pkg::THR_W-1:0];
                mcid_pkg::REG_CLASS_MAP:  r_class_map      <= i_cfg_data[mcid_pkg::MAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign step = i_valid & o_ready;

    // One lane per channel; channels past the input pins see a constant low.
    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
        logic       lane_raw;
        logic [1:0] lane_class;

        if (ch < mcid_pkg::IN_W) begin : g_pin
            assign lane_raw = i_raw_inputs[ch];
        end else begin : g_nopin
            assign lane_raw = 1'b0;
        end

        if (ch < mcid_pkg::MAP_CHANNELS) begin : g_map
            assign lane_class = r_class_map[2*ch +: 2];
        end else begin : g_nomap
            assign lane_class = mcid_pkg::CLASS_NORMAL;
        end

        mcid_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (step),
            .i_raw      (lane_raw),
            .i_class    (lane_class),
            .i_thr      (r_thr),
            .o_deb      (deb_cur[ch]),
            .o_deb_next (deb_next[ch])
        );
    end

    // Map the lanes onto the eight output bits.
    for (genvar b = 0; b < mcid_pkg::IN_W; b++) begin : g_out
        if (b < NUM_CHANNELS) begin : g_used
            assign out_cur[b]  = deb_cur[b];
            assign out_next[b] = deb_next[b];
        end else begin : g_unused
            assign out_cur[b]  = 1'b0;
            assign out_next[b] = 1'b0;
        end
    end

    mcid_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_deb_cur  (out_cur),
        .i_deb_next (out_next),
        .o_room     (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_debounced_inputs = result.debounced;
    assign o_rose_mask        = result.rose;
    assign o_fell_mask        = result.fell;

endmodule

@@ design/mcid_lane.sv @@
// One debounce lane: disagreement counter and debounced bit of one channel.
module mcid_lane #(
    parameter int COUNT_WIDTH = mcid_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_raw,
    input  logic [1:0]            i_class,
    input  mcid_pkg::t_thresholds i_thr,
    output logic                  o_deb,
    output logic                  o_deb_next
);

    localparam int CMP_W = (COUNT_WIDTH > mcid_pkg::THR_W) ? COUNT_WIDTH : mcid_pkg::THR_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                         r_deb;
    logic                         n_deb;
    logic [COUNT_WIDTH-1:0]       r_cnt;
    logic [COUNT_WIDTH-1:0]       n_cnt;
    logic [COUNT_WIDTH-1:0]       cnt_inc;
    logic [mcid_pkg::THR_W-1:0]   thr;
    logic                         disagree;
    logic                         hit;

    // Pick this channel's threshold from its class.
    always_comb begin
        case (i_class)
            mcid_pkg::CLASS_FAST: thr = i_thr.fast_thr;
            mcid_pkg::CLASS_SLOW: thr = i_thr.slow_thr;
            default:              thr = i_thr.normal_thr;
        endcase
    end

    // Saturating count and flip decision for this tick.
    always_comb begin
        disagree = i_raw ^ r_deb;
        cnt_inc  = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
        hit      = CMP_W'(cnt_inc) >= CMP_W'(thr);
        n_deb    = r_deb;
        n_cnt    = '0;
        if (disagree) begin
            if (hit) begin
                n_deb = ~r_deb;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    // State advances once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= 1'b0;
            r_cnt <= '0;
        end else if (i_step) begin
            r_deb <= n_deb;
            r_cnt <= n_cnt;
        end
    end

    assign o_deb      = r_deb;
    assign o_deb_next = n_deb;

endmodule

@@ design/mcid_merge.sv @@
// Merge stage: edge masks from the lane outputs and a two-entry result buffer.
module mcid_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [mcid_pkg::IN_W-1:0] i_deb_cur,
    input  logic [mcid_pkg::IN_W-1:0] i_deb_next,
    output logic                      o_room,
    output logic                      o_valid,
    input  logic                      i_ready,
    output mcid_pkg::t_result         o_result
);

    mcid_pkg::t_result new_result;
    mcid_pkg::t_result r_main;
    mcid_pkg::t_result r_skid;
    logic              r_main_valid;
    logic              r_skid_valid;
    logic              pop;

    // Combine what the lanes found into one result.
    always_comb begin
        new_result.debounced = i_deb_next;
        new_result.rose      = i_deb_next & ~i_deb_cur;
        new_result.fell      = i_deb_cur & ~i_deb_next;
    end

    assign pop = r_main_valid & i_ready;

    // Valid flags of the main and skid entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_main_valid <= r_skid_valid | i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= r_main_valid;
            end
        end
    end

    // Result payloads; the skid entry catches a transfer while main is stalled.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : new_result;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= new_result;
            end else begin
                r_main <= new_result;
            end
        end
    end

    assign o_room   = ~r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule
